// ----- rtl/core/lpp_pkg.sv -----
// Shared types and constants for the lens phase pixel pipeline.
// Used by every module under rtl/core; depends on nothing.
package lpp_pkg;

	localparam int LEN_W     = 48;
	localparam int DIM_W     = 13;
	localparam int IDX_W     = 12;
	localparam int PIX_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int COORD_W   = 14;
	localparam int R2_W      = 26;
	localparam int ROOT_W    = 32;
	localparam int DIV_W     = LEN_W + 13;

	localparam logic [CFG_IDX_W-1:0] REG_WAVELENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_PITCH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd4;

	localparam logic [LEN_W-1:0] WAVELENGTH_RST  = 48'd10619136;
	localparam logic [LEN_W-1:0] PIXEL_PITCH_RST = 48'd134217728;
	localparam logic [DIM_W-1:0] GRID_SIDE_RST   = 13'd1024;

	// 2*pi in Q3.61, and 4*pi^2 in Q.56 taken from its exact square
	localparam logic [63:0]  TWO_PI_Q61   = 64'hC90FDAA22168C234;
	localparam logic [127:0] TWO_PI_SQ    = {64'd0, TWO_PI_Q61} * {64'd0, TWO_PI_Q61};
	localparam logic [63:0]  FOUR_PI2_Q56 = {2'b00, TWO_PI_SQ[127:66]};

	typedef struct packed {
		logic [LEN_W-1:0] wavelength;
		logic [LEN_W-1:0] pixel_pitch;
		logic [LEN_W-1:0] distance;
		logic [DIM_W-1:0] grid_width;
		logic [DIM_W-1:0] grid_height;
		logic [63:0]      a4;
		logic             a_big;
		logic             wl_zero;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_index;
		logic             in_band;
	} tag_t;

endpackage

// ----- rtl/core/lpp_cfg.sv -----
// Configuration registers and the sequencer that derives a^4 from them.
// Depends on lpp_pkg.
module lpp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpp_pkg::LEN_W-1:0]      cfg_data,
	output lpp_pkg::cfg_t                  cfg,
	output logic                           busy
);
	import lpp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SQ1  = 3'd3;
	localparam logic [2:0] ST_SQ2  = 3'd4;

	logic [LEN_W-1:0] wavelength_q, pixel_pitch_q, distance_q;
	logic [DIM_W-1:0] grid_width_q, grid_height_q;
	logic [2:0]       state_q;
	logic [5:0]       cnt_q;
	logic [63:0]      rem_q, lo_q, quo_q, op_q, a4_q;
	logic [127:0]     acc_q;

	logic [64:0]  rem_ext, rem_sub;
	logic         div_ge;
	logic [63:0]  pp;
	logic [6:0]   shamt;
	logic [127:0] acc_nxt;

	// Write the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wavelength_q  <= WAVELENGTH_RST;
			pixel_pitch_q <= PIXEL_PITCH_RST;
			distance_q    <= '0;
			grid_width_q  <= GRID_SIDE_RST;
			grid_height_q <= GRID_SIDE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WAVELENGTH:  wavelength_q  <= cfg_data;
				REG_PIXEL_PITCH: pixel_pitch_q <= cfg_data;
				REG_DISTANCE:    distance_q    <= cfg_data;
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[DIM_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// One restoring divide step and one 32x32 partial product per cycle
	always_comb begin
		rem_ext = {rem_q, lo_q[63]};
		rem_sub = rem_ext - {17'd0, pixel_pitch_q};
		div_ge  = rem_ext >= {17'd0, pixel_pitch_q};
		pp      = {32'd0, op_q[32*cnt_q[1] +: 32]} * {32'd0, op_q[32*cnt_q[0] +: 32]};
		shamt   = {1'b0, ({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]}), 4'd0} << 1;
		acc_nxt = acc_q + ({64'd0, pp} << shamt);
	end

	// Sequence a = wl*2^62/pitch, then a2 = a*a>>64, then a4 = a2*a2>>64
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else if (cfg_we) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= ST_SQ1;
						cnt_q   <= '0;
					end
				end
				ST_SQ1: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd3) begin
						state_q <= ST_SQ2;
						cnt_q   <= '0;
					end
				end
				ST_SQ2: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd3) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				rem_q <= {18'd0, wavelength_q[LEN_W-1:2]};
				lo_q  <= {wavelength_q[1:0], 62'd0};
				quo_q <= '0;
			end
			ST_DIV: begin
				rem_q <= div_ge ? rem_sub[63:0] : rem_ext[63:0];
				lo_q  <= {lo_q[62:0], 1'b0};
				quo_q <= {quo_q[62:0], div_ge};
				if (cnt_q == 6'd63) begin
					op_q  <= {quo_q[62:0], div_ge};
					acc_q <= '0;
				end
			end
			ST_SQ1: begin
				acc_q <= acc_nxt;
				if (cnt_q == 6'd3) begin
					op_q  <= acc_nxt[127:64];
					acc_q <= '0;
				end
			end
			ST_SQ2: begin
				acc_q <= acc_nxt;
				if (cnt_q == 6'd3)
					a4_q <= acc_nxt[127:64];
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cfg.wavelength  = wavelength_q;
		cfg.pixel_pitch = pixel_pitch_q;
		cfg.distance    = distance_q;
		cfg.grid_width  = grid_width_q;
		cfg.grid_height = grid_height_q;
		cfg.a4          = a4_q;
		cfg.a_big       = {2'b00, wavelength_q} >= {pixel_pitch_q, 2'b00};
		cfg.wl_zero     = (wavelength_q == '0);
	end

endmodule

// ----- rtl/core/lpp_geom.sv -----
// Front stages: centering, linear index, r2, r2*a4, band test and root operand.
// Depends on lpp_pkg.
module lpp_geom (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  logic [lpp_pkg::IDX_W-1:0]  col,
	input  logic [lpp_pkg::IDX_W-1:0]  row,
	input  lpp_pkg::cfg_t              cfg,
	output logic                       out_valid,
	output logic [63:0]                out_val,
	output lpp_pkg::tag_t              out_tag
);
	import lpp_pkg::*;

	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [COORD_W-1:0] x_s1, y_s1;
	logic [PIX_W-1:0]          idx_s1, idx_s2, idx_s3;
	logic [R2_W-1:0]           r2_s2;
	logic                      nz_s2, nz_s3;
	logic [57:0]               plo_s3, phi_s3;
	logic [63:0]               val_s4;
	tag_t                      tag_s4;

	logic signed [COORD_W-1:0] x_c, y_c;
	logic [24:0]               rw_c;
	logic signed [27:0]        xx_c, yy_c;
	logic [R2_W-1:0]           r2_c;
	logic [89:0]               prod_c;
	logic                      band_c;
	logic [63:0]               d_c;

	always_comb begin
		x_c    = $signed({2'b00, col}) - $signed({2'b00, cfg.grid_width[DIM_W-1:1]})
			+ 14'sd1;
		y_c    = $signed({2'b00, row}) - $signed({2'b00, cfg.grid_height[DIM_W-1:1]})
			+ 14'sd1;
		rw_c   = {13'd0, row} * {12'd0, cfg.grid_width};
		xx_c   = x_s1 * x_s1;
		yy_c   = y_s1 * y_s1;
		r2_c   = xx_c[R2_W-1:0] + yy_c[R2_W-1:0];
		prod_c = {phi_s3, 32'd0} + {32'd0, plo_s3};
		band_c = !nz_s3 || (!cfg.a_big && (prod_c <= {26'd0, FOUR_PI2_Q56}));
		d_c    = FOUR_PI2_Q56 - ((nz_s3 && band_c) ? prod_c[63:0] : 64'd0);
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= x_c;
			y_s1   <= y_c;
			idx_s1 <= {12'd0, col} + rw_c[PIX_W-1:0];
			r2_s2  <= r2_c;
			nz_s2  <= (r2_c != '0);
			idx_s2 <= idx_s1;
			plo_s3 <= {32'd0, r2_s2} * {26'd0, cfg.a4[31:0]};
			phi_s3 <= {32'd0, r2_s2} * {26'd0, cfg.a4[63:32]};
			nz_s3  <= nz_s2;
			idx_s3 <= idx_s2;
			val_s4 <= {d_c[61:0], 2'b00};
			tag_s4.pixel_index <= idx_s3;
			tag_s4.in_band     <= band_c;
		end
	end

	assign out_valid = valid_s4;
	assign out_val   = val_s4;
	assign out_tag   = tag_s4;

endmodule

// ----- rtl/core/lpp_sqrt.sv -----
// Pipelined integer square root, two radicand bits per stage, 32 stages.
// Depends on lpp_pkg.
module lpp_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [63:0]                 in_val,
	input  lpp_pkg::tag_t               in_tag,
	output logic                        out_valid,
	output logic [lpp_pkg::ROOT_W-1:0]  out_root,
	output lpp_pkg::tag_t               out_tag
);
	import lpp_pkg::*;

	localparam int NS = ROOT_W;

	logic              vld_s  [0:NS-1];
	logic [63:0]       val_s  [0:NS-1];
	logic [33:0]       rem_s  [0:NS-1];
	logic [ROOT_W-1:0] root_s [0:NS-1];
	tag_t              tag_s  [0:NS-1];

	logic [63:0]       val_n  [0:NS-1];
	logic [33:0]       rem_n  [0:NS-1];
	logic [ROOT_W-1:0] root_n [0:NS-1];

	// One digit step per stage
	always_comb begin
		logic [63:0]       v;
		logic [33:0]       r;
		logic [ROOT_W-1:0] rt;
		logic [35:0]       rin, trial, diff;
		logic              ge;
		for (int i = 0; i < NS; i++) begin
			if (i == 0) begin
				v  = in_val;
				r  = '0;
				rt = '0;
			end else begin
				v  = val_s[i-1];
				r  = rem_s[i-1];
				rt = root_s[i-1];
			end
			rin       = {r, v[63:62]};
			trial     = {2'b00, rt, 2'b01};
			ge        = rin >= trial;
			diff      = rin - trial;
			rem_n[i]  = ge ? diff[33:0] : rin[33:0];
			root_n[i] = {rt[ROOT_W-2:0], ge};
			val_n[i]  = {v[61:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++)
				vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < NS; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[0] <= in_tag;
			for (int i = 1; i < NS; i++)
				tag_s[i] <= tag_s[i-1];
			for (int i = 0; i < NS; i++) begin
				val_s[i]  <= val_n[i];
				rem_s[i]  <= rem_n[i];
				root_s[i] <= root_n[i];
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_root  = root_s[NS-1];
	assign out_tag   = tag_s[NS-1];

endmodule

// ----- rtl/core/lpp_scale.sv -----
// Scales the root by distance/wavelength: split multiply, then a pipelined
// restoring divider of one quotient bit per stage. Depends on lpp_pkg.
module lpp_scale (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [lpp_pkg::ROOT_W-1:0]  in_root,
	input  lpp_pkg::tag_t               in_tag,
	input  lpp_pkg::cfg_t               cfg,
	output logic                        out_valid,
	output logic [lpp_pkg::LEN_W-1:0]   out_quo,
	output logic                        out_sat,
	output lpp_pkg::tag_t               out_tag
);
	import lpp_pkg::*;

	localparam int NS = LEN_W;

	logic             valid_s1, valid_s2;
	logic [55:0]      plo_s1, phi_s1;
	tag_t             tag_s1, tag_s2;
	logic [DIV_W-1:0] rem_s2;
	logic [LEN_W-1:0] low_s2;
	logic             sat_s2;

	logic             vld_s [0:NS-1];
	logic [DIV_W-1:0] rem_s [0:NS-1];
	logic [LEN_W-1:0] low_s [0:NS-1];
	logic [LEN_W-1:0] quo_s [0:NS-1];
	logic             sat_s [0:NS-1];
	tag_t             tag_s [0:NS-1];

	logic [DIV_W-1:0] rem_n [0:NS-1];
	logic [LEN_W-1:0] low_n [0:NS-1];
	logic [LEN_W-1:0] quo_n [0:NS-1];

	logic [DIV_W-1:0] dvs;
	logic [79:0]      p_c;

	assign dvs = {cfg.wavelength, 13'd0};
	assign p_c = {phi_s1, 24'd0} + {24'd0, plo_s1};

	// One quotient bit per stage
	always_comb begin
		logic [DIV_W-1:0] r;
		logic [LEN_W-1:0] lw, qq;
		logic [DIV_W:0]   rin, diff;
		logic             ge;
		for (int i = 0; i < NS; i++) begin
			if (i == 0) begin
				r  = rem_s2;
				lw = low_s2;
				qq = '0;
			end else begin
				r  = rem_s[i-1];
				lw = low_s[i-1];
				qq = quo_s[i-1];
			end
			rin      = {r, lw[LEN_W-1]};
			ge       = rin >= {1'b0, dvs};
			diff     = rin - {1'b0, dvs};
			rem_n[i] = ge ? diff[DIV_W-1:0] : rin[DIV_W-1:0];
			low_n[i] = {lw[LEN_W-2:0], 1'b0};
			quo_n[i] = {qq[LEN_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int i = 0; i < NS; i++)
				vld_s[i] <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			vld_s[0] <= valid_s2;
			for (int i = 1; i < NS; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s1 <= {24'd0, in_root} * {32'd0, cfg.distance[23:0]};
			phi_s1 <= {24'd0, in_root} * {32'd0, cfg.distance[47:24]};
			tag_s1 <= in_tag;
			rem_s2 <= {29'd0, p_c[79:48]};
			low_s2 <= p_c[47:0];
			sat_s2 <= {29'd0, p_c[79:48]} >= dvs;
			tag_s2 <= tag_s1;
			sat_s[0] <= sat_s2;
			tag_s[0] <= tag_s2;
			for (int i = 1; i < NS; i++) begin
				sat_s[i] <= sat_s[i-1];
				tag_s[i] <= tag_s[i-1];
			end
			for (int i = 0; i < NS; i++) begin
				rem_s[i] <= rem_n[i];
				low_s[i] <= low_n[i];
				quo_s[i] <= quo_n[i];
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_quo   = quo_s[NS-1];
	assign out_sat   = sat_s[NS-1];
	assign out_tag   = tag_s[NS-1];

endmodule

// ----- rtl/core/lens_phase_pixel.sv -----
// Top level of the lens phase pixel pipeline.
// Depends on lpp_pkg, lpp_cfg, lpp_geom, lpp_sqrt and lpp_scale.
//
// Usage: each item on the s_ side is one pixel (col, row); each item on the
// m_ side is its phase in Q32.16 radians, its linear index and an in-band flag.
// The user must write registers through cfg_we/cfg_index/cfg_data only while
// no item is in flight; the block itself does not enforce this. Every write
// restarts the a^4 sequencer (64 divide steps and two four-step multiplies),
// during which s_tready stays low. After reset the same sequencer runs once,
// and s_tready stays low until it finishes.
// Throughput: one item per cycle while the sequencer is idle and the output is
// not stalled; every stage is a short add/compare or at most two multipliers
// of at most 32x32 bits. From acceptance to m_tvalid an item passes 4 front
// stages, 32 root stages, 2 multiply stages, 48 divide stages and the
// output register. When m_tvalid is high and the receiver holds m_tready low,
// the whole pipeline holds in place and s_tready drops; no item is lost or repeated.
module lens_phase_pixel (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lpp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lpp_pkg::LEN_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,  // col[11:0], row[23:12]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [71:0]                   m_tdata,  // phase_value[47:0], pixel_index[71:48]
	output logic                          m_tuser   // in_band, or zero wavelength
);
	import lpp_pkg::*;

	cfg_t              cfg;
	logic              busy;
	logic              adv;
	logic              g_valid, q_valid, d_valid;
	logic [63:0]       g_val;
	tag_t              g_tag, q_tag, d_tag;
	logic [ROOT_W-1:0] q_root;
	logic [LEN_W-1:0]  d_quo;
	logic              d_sat;

	logic             m_tvalid_q;
	logic [LEN_W-1:0] phase_q;
	logic [PIX_W-1:0] index_q;
	logic             band_q;
	logic [LEN_W-1:0] phase_c;

	// Hold the whole pipeline while the output item waits
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv && !busy;

	lpp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.busy      (busy)
	);

	lpp_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid && s_tready),
		.col       (s_tdata[11:0]),
		.row       (s_tdata[23:12]),
		.cfg       (cfg),
		.out_valid (g_valid),
		.out_val   (g_val),
		.out_tag   (g_tag)
	);

	lpp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (g_valid),
		.in_val    (g_val),
		.in_tag    (g_tag),
		.out_valid (q_valid),
		.out_root  (q_root),
		.out_tag   (q_tag)
	);

	lpp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (q_valid),
		.in_root   (q_root),
		.in_tag    (q_tag),
		.cfg       (cfg),
		.out_valid (d_valid),
		.out_quo   (d_quo),
		.out_sat   (d_sat),
		.out_tag   (d_tag)
	);

	// Pick the phase: zero wavelength, out of band, saturated or quotient
	always_comb begin
		if (cfg.wl_zero)
			phase_c = (cfg.distance != '0) ? {LEN_W{1'b1}} : '0;
		else if (!d_tag.in_band)
			phase_c = '0;
		else if (d_sat)
			phase_c = {LEN_W{1'b1}};
		else
			phase_c = d_quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (adv)
			m_tvalid_q <= d_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_q <= phase_c;
			index_q <= d_tag.pixel_index;
			band_q  <= d_tag.in_band || cfg.wl_zero;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {index_q, phase_q};
	assign m_tuser  = band_q;

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready)
		else $error("input taken while a^4 is being derived");

	a_write_starts_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("register write did not restart the sequencer");

	a_out_band_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[47:0] == '0))
		else $error("out-of-band item carries a nonzero phase");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while the pipeline is stalled");

endmodule
